FILE: design/ratp_pkg.sv
package ratp_pkg;

  // Sine table geometry (quarter wave)
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned ROM_AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned POS_W   = 15;            // mirrored position, 0..16384
  localparam int unsigned IDXP_W  = POS_W + IDX_W;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Field and register widths
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned SPEED_W    = 32;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned LP_W       = 40;
  localparam int unsigned DELTA_W    = 41;
  localparam int unsigned PG_W       = 18;
  localparam int unsigned IG_W       = 18;
  localparam int unsigned SS_W       = 20;
  localparam int unsigned FC_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned MUL_A_W    = 41;
  localparam int unsigned MUL_B_W    = 20;
  localparam int unsigned PROD_W     = 62;
  localparam int unsigned ACC_W      = 51;

  // Register reset values
  localparam logic [PG_W-1:0] PROP_GAIN_RST   = 18'd128000;
  localparam logic [IG_W-1:0] INTEG_GAIN_RST  = 18'd1000;
  localparam logic [SS_W-1:0] STEP_SCALE_RST  = 20'd42722;
  localparam logic [FC_W-1:0] FILTER_COEF_RST = 16'd328;

  localparam logic signed [ERR_W-1:0] SINE_MAX = 16'sd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_STEP_SCALE,
    CFG_FILTER_COEF
  } cfg_reg_e;

  typedef struct packed {
    logic [PG_W-1:0] prop_gain;
    logic [IG_W-1:0] integ_gain;
    logic [SS_W-1:0] step_scale;
    logic [FC_W-1:0] filter_coef;
  } cfg_t;

  // Shared multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_PROP_ERR,
    MUL_INTEG,
    MUL_STEP,
    MUL_FILTER
  } mul_sel_e;

  // Datapath control word
  typedef struct packed {
    logic     ld_diff;
    logic     ld_err;
    logic     ld_integ;
    mul_sel_e mul_sel;
    logic     ld_acc;
    logic     ld_speed;
    logic     ld_delta;
    logic     ld_angle;
    logic     ld_out;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // Taylor divisors (2k)(2k+1), k = 1..6
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156};

  typedef logic [ERR_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Elaboration-time table build, Q30 series rounded to Q1.15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            r;
    for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = HALF_PI_Q30 * 64'(i) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = longint'((longint'(unsigned'(sum)) + 64'd16384) >>> 15);
      if (r > 32767) begin
        r = 32767;
      end
      rom[i] = ERR_W'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: design/ratp_seq.sv
module ratp_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ratp_pkg::dp_stat_t  stat_i,
  output logic                in_ready_o,
  output ratp_pkg::dp_ctrl_t  ctrl_o
);
  import ratp_pkg::*;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_SINE,
    ST_INTEG,
    ST_PROP,
    ST_SPEED,
    ST_STEP,
    ST_ANGLE,
    ST_OUT
  } step_e;

  typedef enum logic [1:0] {
    JMP_GO,     // always advance
    JMP_IN,     // advance on input item
    JMP_OUT     // advance once output register is free
  } jmp_e;

  typedef struct packed {
    jmp_e     jmp;
    step_e    target;
    dp_ctrl_t ctl;
  } ucode_t;

  // Microprogram ROM
  function automatic ucode_t ucode(step_e s);
    ucode_t u;
    u = '0;
    unique case (s)
      ST_FETCH: begin
        u.jmp = JMP_IN;  u.target = ST_SINE;  u.ctl.ld_diff = 1'b1;
      end
      ST_SINE: begin
        u.jmp = JMP_GO;  u.target = ST_INTEG; u.ctl.ld_err = 1'b1;
      end
      ST_INTEG: begin
        u.jmp = JMP_GO;  u.target = ST_PROP;  u.ctl.ld_integ = 1'b1;
        u.ctl.mul_sel = MUL_PROP_ERR;
      end
      ST_PROP: begin
        u.jmp = JMP_GO;  u.target = ST_SPEED; u.ctl.ld_acc = 1'b1;
        u.ctl.mul_sel = MUL_INTEG;
      end
      ST_SPEED: begin
        u.jmp = JMP_GO;  u.target = ST_STEP;  u.ctl.ld_speed = 1'b1;
      end
      ST_STEP: begin
        u.jmp = JMP_GO;  u.target = ST_ANGLE; u.ctl.ld_delta = 1'b1;
        u.ctl.mul_sel = MUL_STEP;
      end
      ST_ANGLE: begin
        u.jmp = JMP_GO;  u.target = ST_OUT;   u.ctl.ld_angle = 1'b1;
        u.ctl.mul_sel = MUL_FILTER;
      end
      ST_OUT: begin
        u.jmp = JMP_OUT; u.target = ST_FETCH; u.ctl.ld_out = 1'b1;
      end
    endcase
    return u;
  endfunction

  step_e  step_q, step_d;
  ucode_t cur;
  logic   go;

  always_comb begin
    cur = ucode(step_q);
    unique case (cur.jmp)
      JMP_GO:  go = 1'b1;
      JMP_IN:  go = in_valid_i;
      JMP_OUT: go = ~stat_i.out_busy;
      default: go = 1'b0;
    endcase
    step_d     = go ? cur.target : step_q;
    in_ready_o = (cur.jmp == JMP_IN);
    ctrl_o     = go ? cur.ctl : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: design/ratp_dp.sv
module ratp_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ratp_pkg::dp_ctrl_t                    ctrl_i,
  input  ratp_pkg::cfg_t                        cfg_i,
  input  logic [ratp_pkg::ANGLE_W-1:0]          measured_angle_i,
  input  logic                                  out_ready_i,
  output ratp_pkg::dp_stat_t                    stat_o,
  output logic                                  out_valid_o,
  output logic [ratp_pkg::ANGLE_W-1:0]          tracked_angle_o,
  output logic signed [ratp_pkg::SPEED_W-1:0]   raw_speed_o,
  output logic signed [ratp_pkg::SPEED_W-1:0]   filtered_speed_o,
  output logic signed [ratp_pkg::ERR_W-1:0]     phase_error_o
);
  import ratp_pkg::*;

  // Loop state
  logic        [ANGLE_W-1:0] angle_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [LP_W-1:0]    lowpass_q;

  // Working registers
  logic        [ANGLE_W-1:0] diff_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic                      out_valid_q;

  // Sine lookup
  logic [1:0]              quad;
  logic [POS_W-1:0]        pos;
  logic [IDXP_W-1:0]       idx_wide;
  logic [IDX_W-1:0]        idx;
  logic signed [ERR_W-1:0] mag;
  logic signed [ERR_W-1:0] err_d;

  always_comb begin
    quad     = diff_q[ANGLE_W-1 -: 2];
    pos      = {1'b0, diff_q[ANGLE_W-3:0]};
    if (quad[0]) begin
      pos = POS_W'(15'd16384 - pos);
    end
    idx_wide = IDXP_W'(pos) * IDXP_W'(SINE_TABLE_DEPTH);
    idx      = idx_wide[14 +: IDX_W];
    mag      = (idx >= IDX_W'(SINE_TABLE_DEPTH)) ? SINE_MAX
                                                 : signed'(SINE_ROM[idx[ROM_AW-1:0]]);
    err_d    = quad[1] ? -mag : mag;
  end

  // Saturating integrator
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_d;

  always_comb begin
    integ_sum = {integ_q[INTEG_W-1], integ_q} + (INTEG_W+1)'(err_q);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_d = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                   : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end
  end

  // Shared multiplier, signed by unsigned
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W:0]   mul_b_s;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_PROP_ERR: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_W'(cfg_i.prop_gain);
      end
      MUL_INTEG: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = MUL_B_W'(cfg_i.integ_gain);
      end
      MUL_STEP: begin
        mul_a = MUL_A_W'(speed_q);
        mul_b = cfg_i.step_scale;
      end
      MUL_FILTER: begin
        mul_a = delta_q;
        mul_b = MUL_B_W'(cfg_i.filter_coef);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_b_s = {1'b0, mul_b};
    mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b_s);
  end

  // PI sum, floor shift by 15, saturate
  localparam int unsigned SH_W = ACC_W - 15;
  logic signed [ACC_W-1:0]   pi_sum;
  logic signed [SH_W-1:0]    pi_sh;
  logic signed [SPEED_W-1:0] speed_d;

  always_comb begin
    pi_sum = acc_q + prod_q[ACC_W-1:0];
    pi_sh  = pi_sum[ACC_W-1:15];
    if (pi_sh[SH_W-1:SPEED_W-1] != {(SH_W-SPEED_W+1){pi_sh[SH_W-1]}}) begin
      speed_d = pi_sh[SH_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                              : {1'b0, {(SPEED_W-1){1'b1}}};
    end else begin
      speed_d = pi_sh[SPEED_W-1:0];
    end
  end

  logic signed [DELTA_W-1:0] delta_d;
  logic signed [LP_W-1:0]    lowpass_d;

  assign delta_d   = {speed_q[SPEED_W-1], speed_q, 8'd0} - {lowpass_q[LP_W-1], lowpass_q};
  assign lowpass_d = lowpass_q + prod_q[LP_W+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q     <= '0;
      integ_q     <= '0;
      lowpass_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.ld_integ) begin
        integ_q <= integ_d;
      end
      if (ctrl_i.ld_angle) begin
        angle_q <= angle_q + prod_q[ANGLE_W+23:24];
      end
      if (ctrl_i.ld_out) begin
        lowpass_q   <= lowpass_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_diff) begin
      diff_q <= measured_angle_i - angle_q;
    end
    if (ctrl_i.ld_err) begin
      err_q <= err_d;
    end
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (ctrl_i.ld_acc) begin
      acc_q <= prod_q[ACC_W-1:0];
    end
    if (ctrl_i.ld_speed) begin
      speed_q <= speed_d;
    end
    if (ctrl_i.ld_delta) begin
      delta_q <= delta_d;
    end
    if (ctrl_i.ld_out) begin
      tracked_angle_o  <= angle_q;
      raw_speed_o      <= speed_q;
      filtered_speed_o <= lowpass_d[LP_W-1:8];
      phase_error_o    <= err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

FILE: design/rotor_angle_tracking_pll.sv
// Rotor angle tracking PLL with a PI loop filter.
// Input channel (in_valid_i/in_ready_o): one measured electrical angle per
//   item, 65536 counts per turn, typically one per PWM period.
// Output channel (out_valid_o/out_ready_i): one result item per input item:
//   tracked angle after the advance, raw PI speed (Q24.8 rad/s), low-pass
//   speed, and phase error sin(measured - tracked) in Q1.15.
// Config channel (cfg_valid_i/cfg_ready_o): register index and data; always
//   ready. Write only while no item is in flight.
// Sequencing: a small microprogram of 8 steps drives one shared multiplier.
//   A new item is taken only after the last one has run through all steps,
//   as the four chained products share the single multiplier.
// Output is registered: the next item is accepted while a result waits.
//   If the receiver stalls, the final step holds until the output register
//   frees up, and the input stays not-ready meanwhile.
// Reset: angle, integrator and filter clear to zero, configuration registers
//   return to their defaults, and the block is ready for an item once reset is released.
module rotor_angle_tracking_pll (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ratp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ratp_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ratp_pkg::ANGLE_W-1:0]           measured_angle_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [ratp_pkg::ANGLE_W-1:0]           tracked_angle_o,
  output logic signed [ratp_pkg::SPEED_W-1:0]    raw_speed_o,
  output logic signed [ratp_pkg::SPEED_W-1:0]    filtered_speed_o,
  output logic signed [ratp_pkg::ERR_W-1:0]      phase_error_o
);
  import ratp_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PROP_GAIN_RST;
      cfg_q.integ_gain  <= INTEG_GAIN_RST;
      cfg_q.step_scale  <= STEP_SCALE_RST;
      cfg_q.filter_coef <= FILTER_COEF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data_i[PG_W-1:0];
        CFG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data_i[IG_W-1:0];
        CFG_STEP_SCALE:  cfg_q.step_scale  <= cfg_data_i[SS_W-1:0];
        CFG_FILTER_COEF: cfg_q.filter_coef <= cfg_data_i[FC_W-1:0];
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;

  ratp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (dp_ctrl)
  );

  ratp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (dp_ctrl),
    .cfg_i            (cfg_q),
    .measured_angle_i (measured_angle_i),
    .out_ready_i      (out_ready_i),
    .stat_o           (dp_stat),
    .out_valid_o      (out_valid_o),
    .tracked_angle_o  (tracked_angle_o),
    .raw_speed_o      (raw_speed_o),
    .filtered_speed_o (filtered_speed_o),
    .phase_error_o    (phase_error_o)
  );

`ifndef SYNTH
  // Sequencer leaves the fetch step after an accepted item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready right after an accepted item");

  // The angle difference is only latched on an accepted item
  a_diff_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl.ld_diff |-> (in_valid_i && in_ready_o))
    else $error("angle difference latched without an accepted item");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl.ld_out |-> (!out_valid_o || out_ready_i))
    else $error("result register loaded while previous result pending");

  // Sine magnitude never exceeds full scale, so the negative limit is unused
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_error_o != 16'h8000))
    else $error("phase error at negative full scale");
`endif

endmodule
